### hw/rtl/murabc_pkg.sv
// ----------------------------------------------------------------------------
// murabc_pkg
// Shared types and constants of the first-order Mur boundary update block.
// ----------------------------------------------------------------------------
package murabc_pkg;

	localparam int MAX_DIM_DEF = 64;
	localparam int NUM_STORES  = 12;

	localparam int VAL_W  = 32;
	localparam int COEF_W = 17;
	localparam int SIZE_W = 7;
	localparam int TAN_W  = 6;
	localparam int FACE_W = 3;
	localparam int CIDX_W = 2;
	localparam int CDAT_W = 17;

	localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(64);

	// face codes
	localparam logic [FACE_W-1:0] FACE_X_LO = 3'd0;
	localparam logic [FACE_W-1:0] FACE_X_HI = 3'd1;
	localparam logic [FACE_W-1:0] FACE_Y_LO = 3'd2;
	localparam logic [FACE_W-1:0] FACE_Y_HI = 3'd3;
	localparam logic [FACE_W-1:0] FACE_Z_LO = 3'd4;
	localparam logic [FACE_W-1:0] FACE_Z_HI = 3'd5;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_COEF = 2'd1,
		ST_RANGE   = 2'd2
	} status_t;

	typedef enum logic [CIDX_W-1:0] {
		REG_COEF   = 2'd0,
		REG_SIZE_X = 2'd1,
		REG_SIZE_Y = 2'd2,
		REG_SIZE_Z = 2'd3
	} cfg_reg_t;

endpackage

### hw/rtl/murabc_if.sv
// ----------------------------------------------------------------------------
// murabc_if
// Valid/ready channels of the Mur boundary block: request, response, config.
// ----------------------------------------------------------------------------
interface murabc_req_if;
	logic                                        valid;
	logic                                        ready;
	logic        [murabc_pkg::FACE_W-1:0]        face;
	logic                                        component;
	logic        [murabc_pkg::TAN_W-1:0]         tan_a;
	logic        [murabc_pkg::TAN_W-1:0]         tan_b;
	logic signed [murabc_pkg::VAL_W-1:0]         edge_value;
	logic signed [murabc_pkg::VAL_W-1:0]         inner_value;

	modport source(output valid, face, component, tan_a, tan_b, edge_value, inner_value,
		input ready);
	modport sink(input valid, face, component, tan_a, tan_b, edge_value, inner_value,
		output ready);
endinterface

interface murabc_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [murabc_pkg::VAL_W-1:0] new_edge_value;
	logic        [1:0]                   status;

	modport source(output valid, new_edge_value, status, input ready);
	modport sink(input valid, new_edge_value, status, output ready);
endinterface

interface murabc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [murabc_pkg::CIDX_W-1:0]   index;
	logic [murabc_pkg::CDAT_W-1:0]   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### hw/rtl/murabc_decode.sv
// ----------------------------------------------------------------------------
// murabc_decode
// Request check against coefficient and face extents, and store address.
// ----------------------------------------------------------------------------
module murabc_decode #(
	parameter int MAX_DIM = murabc_pkg::MAX_DIM_DEF,
	parameter int ADDR_W  = 16
) (
	input  logic signed [murabc_pkg::COEF_W-1:0] coef,
	input  logic        [murabc_pkg::SIZE_W-1:0] size_x,
	input  logic        [murabc_pkg::SIZE_W-1:0] size_y,
	input  logic        [murabc_pkg::SIZE_W-1:0] size_z,
	input  logic        [murabc_pkg::FACE_W-1:0] face,
	input  logic                                 component,
	input  logic        [murabc_pkg::TAN_W-1:0]  tan_a,
	input  logic        [murabc_pkg::TAN_W-1:0]  tan_b,
	output murabc_pkg::status_t                  status,
	output logic        [ADDR_W-1:0]             addr
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int CW    = (DIM_W > murabc_pkg::SIZE_W) ? DIM_W : murabc_pkg::SIZE_W;

	logic [murabc_pkg::SIZE_W-1:0] sa, sb;
	logic [CW-1:0]                 sa_c, sb_c, lim_a, lim_b;
	logic                          face_ok;
	logic [murabc_pkg::FACE_W:0]   sel;

	always_comb begin
		face_ok = 1'b1;
		sa      = size_x;
		sb      = size_y;
		unique case (face) inside
			murabc_pkg::FACE_X_LO, murabc_pkg::FACE_X_HI: begin
				sa = size_y;
				sb = size_z;
			end
			murabc_pkg::FACE_Y_LO, murabc_pkg::FACE_Y_HI: begin
				sa = size_x;
				sb = size_z;
			end
			murabc_pkg::FACE_Z_LO, murabc_pkg::FACE_Z_HI: begin
				sa = size_x;
				sb = size_y;
			end
			default: begin
				face_ok = 1'b0;
			end
		endcase
	end

	// clamp to the store extent; the component's own axis loses its last cell
	always_comb begin
		sa_c  = (CW'(sa) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(sa);
		sb_c  = (CW'(sb) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(sb);
		lim_a = sa_c;
		lim_b = sb_c;
		if (!component)
			lim_a = (sa_c != '0) ? sa_c - CW'(1) : '0;
		else
			lim_b = (sb_c != '0) ? sb_c - CW'(1) : '0;
	end

	always_comb begin
		if (coef == '0)
			status = murabc_pkg::ST_NO_COEF;
		else if (!face_ok || CW'(tan_a) >= lim_a || CW'(tan_b) >= lim_b)
			status = murabc_pkg::ST_RANGE;
		else
			status = murabc_pkg::ST_OK;
	end

	// store index: ((face*2 + component) * MAX_DIM + tan_a) * MAX_DIM + tan_b
	assign sel  = {face, component};
	assign addr = ADDR_W'((int'(sel) * MAX_DIM + int'(tan_a)) * MAX_DIM + int'(tan_b));

endmodule

### hw/rtl/mur_first_order_abc_update.sv
// ----------------------------------------------------------------------------
// mur_first_order_abc_update
// First-order Mur absorbing boundary update, one boundary sample per request.
// ----------------------------------------------------------------------------
// Usage:
//  - req: one boundary sample (face, component, tangential indices, boundary
//    and inner field values). rsp: the updated boundary value and a status.
//  - cfg: register writes (coefficient, grid sizes), taken every cycle; write
//    only while no request is in flight.
//  - new = prior + round(coef * (inner - edge) / 2^16), saturated to 32 bits; the
//    inner value is stored as the cell's prior for its next time step.
//  - Zero coefficient, bad face or out-of-extent index: the boundary value
//    comes back unchanged with an error status and the store is untouched.
//  - Throughput: one request per cycle unless the response side stalls. Each
//    request reads and writes its store entry in the same cycle on a read-first RAM port, so back-to-back
//    requests to the same cell need no interlock.
//  - Pipeline: stage 1 reads the RAM at the accept, stage 2 multiplies and
//    stage 3 rounds, adds and saturates into the output register (rsp.valid).
//  - Reset: a sweep clears all 12*MAX_DIM*MAX_DIM entries of the prior store
//    (49152 at the default), and req.ready stays low during the sweep.
//  - Stall: each stage holds while the one behind it is full; req.ready drops
//    only once all three stages hold a result.
// ----------------------------------------------------------------------------
module mur_first_order_abc_update #(
	parameter int MAX_DIM = murabc_pkg::MAX_DIM_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	murabc_req_if.sink    req,
	murabc_rsp_if.source  rsp,
	murabc_cfg_if.sink    cfg
);

	localparam int DEPTH  = murabc_pkg::NUM_STORES * MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int VAL_W  = murabc_pkg::VAL_W;
	localparam int DIFF_W = VAL_W + 1;
	localparam int PROD_W = 50;   // |coef*diff| < 2^48
	localparam int SCL_W  = PROD_W - 16;
	localparam int SUM_W  = SCL_W + 1;

	// config registers
	logic signed [murabc_pkg::COEF_W-1:0] coef_q;
	logic        [murabc_pkg::SIZE_W-1:0] size_x_q, size_y_q, size_z_q;

	// clearing sweep
	logic              clr_q;
	logic [ADDR_W-1:0] clr_cnt_q;

	// decode / accept
	murabc_pkg::status_t dec_status;
	logic [ADDR_W-1:0]   dec_addr;
	logic                acc;
	logic                rdy_s1, rdy_s2, rdy_s3;

	// store port
	logic [VAL_W-1:0]  mem [DEPTH];
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [VAL_W-1:0]  mem_wdata;

	// pipeline
	logic                       vld_s1, vld_s2, vld_s3;
	murabc_pkg::status_t        status_s1, status_s2, status_s3;
	logic signed [VAL_W-1:0]    edge_s1, edge_s2;
	logic signed [VAL_W-1:0]    prior_s1, prior_s2;
	logic signed [DIFF_W-1:0]   diff_s1;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [VAL_W-1:0]    new_s3;

	logic signed [PROD_W-1:0]   prod_rnd;
	logic signed [SCL_W-1:0]    scaled;
	logic signed [SUM_W-1:0]    sum;
	logic signed [VAL_W-1:0]    sum_sat;

	// ---------------------------------------------------------------- config
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q   <= '0;
			size_x_q <= murabc_pkg::SIZE_RST;
			size_y_q <= murabc_pkg::SIZE_RST;
			size_z_q <= murabc_pkg::SIZE_RST;
		end else if (cfg.valid) begin
			unique case (murabc_pkg::cfg_reg_t'(cfg.index))
				murabc_pkg::REG_COEF:   coef_q   <= murabc_pkg::COEF_W'(cfg.data);
				murabc_pkg::REG_SIZE_X: size_x_q <= cfg.data[murabc_pkg::SIZE_W-1:0];
				murabc_pkg::REG_SIZE_Y: size_y_q <= cfg.data[murabc_pkg::SIZE_W-1:0];
				murabc_pkg::REG_SIZE_Z: size_z_q <= cfg.data[murabc_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------ clear sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			if (clr_cnt_q == ADDR_W'(DEPTH - 1))
				clr_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------- decode
	murabc_decode #(
		.MAX_DIM (MAX_DIM),
		.ADDR_W  (ADDR_W)
	) u_decode (
		.coef      (coef_q),
		.size_x    (size_x_q),
		.size_y    (size_y_q),
		.size_z    (size_z_q),
		.face      (req.face),
		.component (req.component),
		.tan_a     (req.tan_a),
		.tan_b     (req.tan_b),
		.status    (dec_status),
		.addr      (dec_addr)
	);

	// per-stage flow control: a stage moves when it is empty or the next moves
	assign rdy_s3    = !vld_s3 || rsp.ready;
	assign rdy_s2    = !vld_s2 || rdy_s3;
	assign rdy_s1    = !vld_s1 || rdy_s2;
	assign req.ready = rdy_s1 && !clr_q;
	assign acc       = req.valid && req.ready;

	// ----------------------------------------------------------------- store
	// read-first: the read returns the prior while the same edge stores inner
	assign mem_we    = clr_q || (acc && dec_status == murabc_pkg::ST_OK);
	assign mem_waddr = clr_q ? clr_cnt_q : dec_addr;
	assign mem_wdata = clr_q ? '0 : req.inner_value;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (acc)
			prior_s1 <= $signed(mem[dec_addr]);
	end

	// --------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (rdy_s1)
			vld_s1 <= acc;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1 <= dec_status;
			edge_s1   <= req.edge_value;
			diff_s1   <= DIFF_W'(req.inner_value) - DIFF_W'(req.edge_value);
		end
	end

	// --------------------------------------------------------- stage 2: mult
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (rdy_s2)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			status_s2 <= status_s1;
			edge_s2   <= edge_s1;
			prior_s2  <= prior_s1;
			prod_s2   <= PROD_W'(coef_q) * PROD_W'(diff_s1);
		end
	end

	// ------------------------------------------ stage 3: round, add, saturate
	// round to nearest, ties up: floor((p + 2^15) / 2^16)
	assign prod_rnd = prod_s2 + PROD_W'(32768);
	assign scaled   = prod_rnd[PROD_W-1:16];
	assign sum      = SUM_W'(prior_s2) + SUM_W'(scaled);

	always_comb begin
		if (sum[SUM_W-1:VAL_W-1] == '0 || sum[SUM_W-1:VAL_W-1] == '1)
			sum_sat = sum[VAL_W-1:0];
		else if (sum[SUM_W-1])
			sum_sat = {1'b1, {(VAL_W-1){1'b0}}};
		else
			sum_sat = {1'b0, {(VAL_W-1){1'b1}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (rdy_s3)
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			status_s3 <= status_s2;
			new_s3    <= (status_s2 == murabc_pkg::ST_OK) ? sum_sat : edge_s2;
		end
	end

	assign rsp.valid          = vld_s3;
	assign rsp.new_edge_value = new_s3;
	assign rsp.status         = status_s3;

`ifndef NO_ASSERTIONS
	// no request gets in while the store is still being cleared
	a_no_acc_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !acc)
		else $error("request accepted during store clear");

	// a rejected request never touches the store
	a_no_wr_err: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && dec_status != murabc_pkg::ST_OK) |-> !mem_we)
		else $error("store written for rejected request");

	// an accepted request always lands in stage 1
	a_acc_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> vld_s1)
		else $error("accepted request lost before stage 1");

	// a stalled product holds
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !rdy_s3) |=> (vld_s2 && $stable(prod_s2)))
		else $error("stage 2 product changed while stalled");

	// a good result needs a programmed coefficient
	a_ok_coef: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && status_s3 == murabc_pkg::ST_OK) |-> (coef_q != '0))
		else $error("ok status with zero coefficient");
`endif

endmodule

### sim/mur_first_order_abc_update_check.sv
// ----------------------------------------------------------------------------
// mur_first_order_abc_update_check
// Passive checker for the Mur boundary block. It follows register writes,
// predicts every accepted request with its own copy of the twelve prior
// stores and compares the responses in order, field by field.
// ----------------------------------------------------------------------------
module mur_first_order_abc_update_check #(
	parameter int MAX_DIM = murabc_pkg::MAX_DIM_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	murabc_req_if req,
	murabc_rsp_if rsp,
	murabc_cfg_if cfg,
	output int    outstanding,
	output int    mismatches
);
	import murabc_pkg::*;

	localparam int PLANE = MAX_DIM * MAX_DIM;

	typedef struct {
		logic signed [VAL_W-1:0] value;
		status_t                 status;
	} boundary_result_t;

	logic signed [VAL_W-1:0]  prior_inner [NUM_STORES*PLANE];
	logic signed [COEF_W-1:0] coef;
	logic [SIZE_W-1:0]        size_x, size_y, size_z;
	boundary_result_t         boundary_q [$];

	// oversized grid registers saturate at the store extent
	function automatic int extent(input logic [SIZE_W-1:0] s);
		return (int'(s) > MAX_DIM) ? MAX_DIM : int'(s);
	endfunction

	function automatic boundary_result_t update_boundary(
		input logic [FACE_W-1:0]       face,
		input logic                    comp,
		input logic [TAN_W-1:0]        ta,
		input logic [TAN_W-1:0]        tb,
		input logic signed [VAL_W-1:0] edge_v,
		input logic signed [VAL_W-1:0] inner_v
	);
		boundary_result_t res;
		int sa, sb, lim_a, lim_b, slot;
		longint diff, prod, scaled, sum;
		res.value  = edge_v;
		res.status = ST_OK;
		if (coef == '0) begin
			res.status = ST_NO_COEF;
		end else if (face > FACE_Z_HI) begin
			res.status = ST_RANGE;
		end else begin
			case (face)
				FACE_X_LO, FACE_X_HI: begin
					sa = extent(size_y);
					sb = extent(size_z);
				end
				FACE_Y_LO, FACE_Y_HI: begin
					sa = extent(size_x);
					sb = extent(size_z);
				end
				default: begin
					sa = extent(size_x);
					sb = extent(size_y);
				end
			endcase
			lim_a = sa;
			lim_b = sb;
			// the axis a component lies along loses its last cell
			if (!comp)
				lim_a = (sa > 0) ? sa - 1 : 0;
			else
				lim_b = (sb > 0) ? sb - 1 : 0;
			if (int'(ta) >= lim_a || int'(tb) >= lim_b) begin
				res.status = ST_RANGE;
			end else begin
				slot   = (int'(face) * 2 + int'(comp)) * PLANE + int'(ta) * MAX_DIM + int'(tb);
				diff   = longint'(inner_v) - longint'(edge_v);
				prod   = longint'(coef) * diff;
				// round half up from 16 fraction bits to an integer
				scaled = (prod + 64'sd32768) >>> 16;
				sum    = longint'(prior_inner[slot]) + scaled;
				if (sum > 64'sd2147483647)
					sum = 64'sd2147483647;
				if (sum < -64'sd2147483648)
					sum = -64'sd2147483648;
				prior_inner[slot] = inner_v;
				res.value = sum[VAL_W-1:0];
			end
		end
		return res;
	endfunction

	initial begin
		outstanding = 0;
		mismatches  = 0;
		foreach (prior_inner[i])
			prior_inner[i] = '0;
	end

	always @(posedge clk) begin
		boundary_result_t want;
		if (!arst_n) begin
			coef   = '0;
			size_x = SIZE_RST;
			size_y = SIZE_RST;
			size_z = SIZE_RST;
			boundary_q.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (boundary_q.size() == 0) begin
					mismatches++;
					$display("%0t stray response: expected none, got %h status %0d",
						$time, rsp.new_edge_value, rsp.status);
				end else begin
					want = boundary_q.pop_front();
					if (rsp.new_edge_value !== want.value) begin
						mismatches++;
						$display("%0t new_edge_value: expected %h, got %h",
							$time, want.value, rsp.new_edge_value);
					end
					if (rsp.status !== want.status) begin
						mismatches++;
						$display("%0t status: expected %0d, got %0d",
							$time, want.status, rsp.status);
					end
				end
			end
			if (req.valid && req.ready)
				boundary_q.push_back(update_boundary(req.face, req.component, req.tan_a,
					req.tan_b, req.edge_value, req.inner_value));
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_COEF:   coef   = cfg.data;
					REG_SIZE_X: size_x = cfg.data[SIZE_W-1:0];
					REG_SIZE_Y: size_y = cfg.data[SIZE_W-1:0];
					REG_SIZE_Z: size_z = cfg.data[SIZE_W-1:0];
					default: ;
				endcase
			end
		end
		outstanding = boundary_q.size();
	end

endmodule

### sim/mur_first_order_abc_update_test.sv
// ----------------------------------------------------------------------------
// mur_first_order_abc_update_test
// Regression for the Mur boundary update: a directed set of corner requests
// (saturation, rounding ties, bad faces, extents, unset coefficient), then
// randomized phases under several grid and coefficient settings, with random
// gaps on both sides and one long response stall. The checker beside the
// block predicts and compares; this module only drives and rules.
// ----------------------------------------------------------------------------
module mur_first_order_abc_update_test;
	import murabc_pkg::*;

	localparam int LIMIT       = 400000;   // reset sweep plus a slow run, many times over
	localparam int HOLD_CYCLES = 120;      // long response stall, fills the pipeline
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 56;

	// face codes past the six real faces
	localparam logic [FACE_W-1:0] FACE_BAD_LO = 3'd6;
	localparam logic [FACE_W-1:0] FACE_BAD_HI = 3'd7;
	localparam logic COMP_A = 1'b0;
	localparam logic COMP_B = 1'b1;

	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic [COEF_W-1:0] COEF_ZERO = 17'h00000;
	localparam logic [COEF_W-1:0] COEF_POS1 = 17'h0FFFF;   // just under +1.0
	localparam logic [COEF_W-1:0] COEF_NEG1 = 17'h10000;   // -1.0
	localparam logic [COEF_W-1:0] COEF_LSB  = 17'h00001;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   outstanding, mismatches, cycles;
	bit   hold_off_pending = 1'b0;

	// grid sizes as last written, used to aim requests inside the faces
	logic [SIZE_W-1:0] grid_x = SIZE_RST, grid_y = SIZE_RST, grid_z = SIZE_RST;

	// sender pacing: runs of back-to-back requests alternate with gappy runs
	int send_run_left = 0;
	bit send_calm     = 1'b0;

	// last address sent, reused now and then to hit one cell back to back
	logic [FACE_W-1:0] last_face = FACE_X_LO;
	logic              last_comp = COMP_A;
	logic [TAN_W-1:0]  last_ta = '0, last_tb = '0;

	murabc_req_if req();
	murabc_rsp_if rsp();
	murabc_cfg_if cfg();

	mur_first_order_abc_update dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	mur_first_order_abc_update_check boundary_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg         (cfg),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// drivers; every one starts and ends on a falling edge
	// ------------------------------------------------------------------

	// one request; valid stays up on return so the next request can follow
	task automatic send_cell(
		input logic [FACE_W-1:0]       face,
		input logic                    comp,
		input logic [TAN_W-1:0]        ta,
		input logic [TAN_W-1:0]        tb,
		input logic signed [VAL_W-1:0] edge_v,
		input logic signed [VAL_W-1:0] inner_v
	);
		int gap;
		if (send_run_left == 0) begin
			send_calm     = ($urandom_range(2) == 0);
			send_run_left = $urandom_range(40, 8);
		end
		send_run_left--;
		gap = send_calm ? 0 : $urandom_range(11);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid       <= 1'b1;
		req.face        <= face;
		req.component   <= comp;
		req.tan_a       <= ta;
		req.tan_b       <= tb;
		req.edge_value  <= edge_v;
		req.inner_value <= inner_v;
		do @(posedge clk); while (!(req.valid && req.ready));
		@(negedge clk);
	endtask

	// drop the request line and wait until every response is back
	task automatic settle();
		req.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t which, input logic [CDAT_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= which;
		cfg.data  <= value;
		do @(posedge clk); while (!(cfg.valid && cfg.ready));
		@(negedge clk);
	endtask

	// write all four registers; size writes sometimes carry junk above bit 6
	task automatic set_grid(
		input logic [COEF_W-1:0] c,
		input logic [SIZE_W-1:0] sx,
		input logic [SIZE_W-1:0] sy,
		input logic [SIZE_W-1:0] sz
	);
		write_reg(REG_COEF, c);
		write_reg(REG_SIZE_X, {($urandom_range(1) ? 10'($urandom) : 10'd0), sx});
		write_reg(REG_SIZE_Y, {($urandom_range(1) ? 10'($urandom) : 10'd0), sy});
		write_reg(REG_SIZE_Z, {($urandom_range(1) ? 10'($urandom) : 10'd0), sz});
		cfg.valid <= 1'b0;
		grid_x = sx;
		grid_y = sy;
		grid_z = sz;
	endtask

	function automatic int reach(input logic [SIZE_W-1:0] s);
		return (int'(s) > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(s);
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(5))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2: return VAL_W'($urandom_range(131072)) - 32'd65536;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size(input int phase);
		if (phase == 3)
			return SIZE_W'($urandom_range(4, 2));
		case ($urandom_range(9))
			0: return SIZE_W'($urandom_range(1));          // degenerate axis
			1: return SIZE_W'($urandom_range(127, 65));    // clamps to the store
			default: return SIZE_W'($urandom_range(64, 2));
		endcase
	endfunction

	// mostly in-extent cells, a hot corner for store reuse, some strays
	task automatic send_random_cell();
		logic [FACE_W-1:0] f;
		logic              c;
		logic [TAN_W-1:0]  ta, tb;
		int sa, sb, lim_a, lim_b;
		if ($urandom_range(99) < 15) begin
			f  = last_face;
			c  = last_comp;
			ta = last_ta;
			tb = last_tb;
		end else begin
			f  = ($urandom_range(99) < 5) ? FACE_W'($urandom_range(7, 6)) : FACE_W'($urandom_range(5));
			c  = 1'($urandom_range(1));
			sa = reach((f < FACE_Y_LO) ? grid_y : grid_x);
			sb = reach((f < FACE_Z_LO) ? grid_z : grid_y);
			lim_a = (c == COMP_A && sa > 0) ? sa - 1 : sa;
			lim_b = (c == COMP_B && sb > 0) ? sb - 1 : sb;
			if ($urandom_range(9) != 0 && lim_a > 0 && lim_b > 0) begin
				if ($urandom_range(2) == 0) begin
					ta = TAN_W'($urandom_range((lim_a > 3) ? 2 : lim_a - 1));
					tb = TAN_W'($urandom_range((lim_b > 3) ? 2 : lim_b - 1));
				end else begin
					ta = TAN_W'($urandom_range(lim_a - 1));
					tb = TAN_W'($urandom_range(lim_b - 1));
				end
			end else begin
				ta = TAN_W'($urandom);
				tb = TAN_W'($urandom);
			end
		end
		last_face = f;
		last_comp = c;
		last_ta   = ta;
		last_tb   = tb;
		send_cell(f, c, ta, tb, pick_value(), pick_value());
	endtask

	// ------------------------------------------------------------------
	// response side: random stalls, calm stretches, one long hold-off
	// ------------------------------------------------------------------
	initial begin : drain
		int gap, run_left;
		bit calm;
		run_left  = 0;
		calm      = 1'b0;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (run_left == 0) begin
				calm     = ($urandom_range(2) == 0);
				run_left = $urandom_range(40, 8);
			end
			run_left--;
			gap = calm ? 0 : $urandom_range(11);
			if (hold_off_pending) begin
				gap = HOLD_CYCLES;
				hold_off_pending = 1'b0;
			end
			if (gap > 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!(rsp.valid && rsp.ready));
			@(negedge clk);
		end
	end

	// watchdog
	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("mur_first_order_abc_update regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// stimulus and verdict
	// ------------------------------------------------------------------
	initial begin : stimulus
		logic [COEF_W-1:0] c;
		req.valid       = 1'b0;
		req.face        = FACE_X_LO;
		req.component   = COMP_A;
		req.tan_a       = '0;
		req.tan_b       = '0;
		req.edge_value  = '0;
		req.inner_value = '0;
		cfg.valid       = 1'b0;
		cfg.index       = REG_COEF;
		cfg.data        = '0;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// coefficient still at reset: echo with error, even for a bad face
		send_cell(FACE_X_LO, COMP_A, 6'd0, 6'd0, VAL_MAX, VAL_MIN);
		send_cell(FACE_BAD_HI, COMP_B, 6'd63, 6'd63, 32'sd0, 32'sh0001_2345);
		settle();

		// full-scale coefficient, full grid
		set_grid(COEF_POS1, 7'd64, 7'd64, 7'd64);
		send_cell(FACE_X_LO, COMP_A, 6'd0, 6'd0, VAL_MIN, VAL_MAX);    // saturates high
		send_cell(FACE_X_LO, COMP_A, 6'd0, 6'd0, VAL_MAX, VAL_MIN);    // large negative step
		send_cell(FACE_X_LO, COMP_A, 6'd0, 6'd0, VAL_MAX, VAL_MIN);    // saturates low
		send_cell(FACE_BAD_LO, COMP_A, 6'd1, 6'd1, 32'sd1, 32'sd2);
		send_cell(FACE_BAD_HI, COMP_B, 6'd1, 6'd1, 32'sd3, 32'sd4);
		send_cell(FACE_Y_LO, COMP_A, 6'd63, 6'd0, pick_value(), pick_value());   // past a-extent
		send_cell(FACE_Y_HI, COMP_A, 6'd62, 6'd63, pick_value(), pick_value());  // last valid
		send_cell(FACE_Z_LO, COMP_B, 6'd0, 6'd63, pick_value(), pick_value());   // past b-extent
		send_cell(FACE_Z_HI, COMP_B, 6'd63, 6'd62, pick_value(), pick_value());  // last valid
		send_cell(FACE_X_HI, COMP_B, 6'd63, 6'd63, pick_value(), pick_value());
		settle();

		// one-LSB coefficient: rounding ties; x=2, y empty, z clamps to 64
		set_grid(COEF_LSB, 7'd2, 7'd0, 7'd127);
		send_cell(FACE_Z_LO, COMP_A, 6'd0, 6'd0, pick_value(), pick_value());   // y empty
		send_cell(FACE_Y_LO, COMP_A, 6'd0, 6'd63, 32'sd0, 32'sh0000_8000);      // tie, rounds up
		send_cell(FACE_Y_LO, COMP_A, 6'd0, 6'd62, 32'sh0000_8000, 32'sd0);      // tie, rounds to zero
		send_cell(FACE_X_LO, COMP_B, 6'd0, 6'd0, pick_value(), pick_value());   // a-axis empty
		send_cell(FACE_Y_HI, COMP_B, 6'd1, 6'd62, pick_value(), pick_value());
		settle();

		// coefficient -1.0, x axis a single cell
		set_grid(COEF_NEG1, 7'd1, 7'd64, 7'd64);
		send_cell(FACE_Y_LO, COMP_A, 6'd0, 6'd0, pick_value(), pick_value());   // no room along x
		send_cell(FACE_Z_HI, COMP_B, 6'd0, 6'd62, pick_value(), pick_value());
		send_cell(FACE_X_HI, COMP_A, 6'd62, 6'd63, VAL_MAX, VAL_MIN);
		send_cell(FACE_X_HI, COMP_A, 6'd62, 6'd63, pick_value(), pick_value());
		settle();

		// random phases; the first one also carries the long response stall
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				2: c = COEF_ZERO;
				3: c = COEF_NEG1;
				4: c = COEF_POS1;
				default: begin
					do c = COEF_W'($urandom); while (c == COEF_ZERO);
				end
			endcase
			if (phase == 0)
				set_grid(c, SIZE_RST, SIZE_RST, SIZE_RST);
			else
				set_grid(c, pick_size(phase), pick_size(phase), pick_size(phase));
			if (phase == 0)
				hold_off_pending = 1'b1;
			repeat (PHASE_ITEMS) send_random_cell();
			settle();
		end

		// let any stray response show up
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("mur_first_order_abc_update regression: pass");
		else
			$display("mur_first_order_abc_update regression: fail");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/murabc_pkg.sv
hw/rtl/murabc_if.sv
hw/rtl/murabc_decode.sv
hw/rtl/mur_first_order_abc_update.sv
sim/mur_first_order_abc_update_check.sv
sim/mur_first_order_abc_update_test.sv
